[rtl/gnss_nav_message_capture_defines.svh]
// Assertion macros shared by the navigation message capture RTL.
`ifndef GNSS_NAV_MESSAGE_CAPTURE_DEFINES_SVH
`define GNSS_NAV_MESSAGE_CAPTURE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GNMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gnmc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GNMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gnmc: next-cycle check failed");

`endif

[rtl/gnmc_pkg.sv]
// Package: types, register indexes and reset values for the message capture block.
`timescale 1ns / 1ps
package gnmc_pkg;

  // Message kinds as carried on msg_kind
  typedef enum logic [1:0] {
    KIND_POS    = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LEN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_LEN = 3'd7;

  localparam int LEN_W = 7;
  localparam int HIST_DEPTH = 5;

  // Register reset values
  localparam logic [7:0]       SYNC_RST       = 8'd98;
  localparam logic [7:0]       CLASS_RST      = 8'd1;
  localparam logic [7:0]       POS_ID_RST     = 8'd2;
  localparam logic [7:0]       TIME_ID_RST    = 8'd33;
  localparam logic [7:0]       STATUS_ID_RST  = 8'd3;
  localparam logic [LEN_W-1:0] POS_LEN_RST    = 7'd28;
  localparam logic [LEN_W-1:0] TIME_LEN_RST   = 7'd20;
  localparam logic [LEN_W-1:0] STATUS_LEN_RST = 7'd16;

  // Byte history fill after reset (ASCII zero)
  localparam logic [7:0] HIST_RST = 8'h30;

  localparam int MAX_PAYLOAD_DEF = 64;

endpackage

[rtl/gnss_nav_message_capture.sv]
// Top level: byte-serial capture of navigation messages with header and message counters.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_stall    | rx_byte
//  output   | out_valid / out_stall  | write_enable .. status_count
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle unless stalled; each byte's result appears in the next cycle.
// The matcher, index and counter update sit between the byte history and the
// result register, a single pass through compares and parallel 16-bit increments.
// A new byte is taken while a result is held, as long as that result is not stalled.
// Reset (rst, synchronous) restores register defaults, fills history with 0x30,
// clears counters, flags and the result valid bit.
// Ready flags and counters on the output belong to the result being held.
`timescale 1ns / 1ps
`include "gnss_nav_message_capture_defines.svh"
module gnss_nav_message_capture #(
  parameter int MAX_PAYLOAD = gnmc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           write_enable,
  output logic [1:0]                     msg_kind,
  output logic [5:0]                     payload_index,
  output logic [7:0]                     payload_byte,
  output logic                           msg_complete,
  output logic                           position_ready,
  output logic                           time_ready,
  output logic                           status_ready,
  output logic [15:0]                    header_count,
  output logic [15:0]                    position_count,
  output logic [15:0]                    time_count,
  output logic [15:0]                    status_count,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gnmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import gnmc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD);
  localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PAYLOAD);

  // Configuration registers
  logic [7:0]       sync_byte, class_byte, position_id, time_id, status_id;
  logic [LEN_W-1:0] position_length, time_length, status_length;

  // Capture state
  logic [7:0]       hist [HIST_DEPTH];
  kind_t            capture_kind, capture_kind_next;
  logic [IDX_W-1:0] capture_index, capture_index_next;
  logic [2:0]       ready_flags, ready_flags_next;
  logic [15:0]      header_counter, position_counter, time_counter, status_counter;
  logic [15:0]      header_counter_next, position_counter_next;
  logic [15:0]      time_counter_next, status_counter_next;

  // Result register
  logic             out_we;
  kind_t            out_kind;
  logic [5:0]       out_index;
  logic [7:0]       out_byte;
  logic             out_done;

  logic             in_accept;
  logic             hdr_hit;
  kind_t            kind_a;
  logic [IDX_W-1:0] idx_a;
  logic             active;
  logic [LEN_W-1:0] cur_len;
  logic [CMP_W-1:0] idx_inc;
  logic [CMP_W-1:0] idx_ext;
  logic             done;
  logic             overflow;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte       <= SYNC_RST;
      class_byte      <= CLASS_RST;
      position_id     <= POS_ID_RST;
      time_id         <= TIME_ID_RST;
      status_id       <= STATUS_ID_RST;
      position_length <= POS_LEN_RST;
      time_length     <= TIME_LEN_RST;
      status_length   <= STATUS_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC:       sync_byte       <= cfg_data;
        REG_CLASS:      class_byte      <= cfg_data;
        REG_POS_ID:     position_id     <= cfg_data;
        REG_TIME_ID:    time_id         <= cfg_data;
        REG_STATUS_ID:  status_id       <= cfg_data;
        REG_POS_LEN:    position_length <= cfg_data[LEN_W-1:0];
        REG_TIME_LEN:   time_length     <= cfg_data[LEN_W-1:0];
        REG_STATUS_LEN: status_length   <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // Header match on the oldest three history bytes; identifier priority
  always_comb begin
    hdr_hit = (hist[0] == sync_byte) && (hist[1] == class_byte);
    kind_a  = capture_kind;
    idx_a   = capture_index;
    if (hdr_hit) begin
      priority if (hist[2] == position_id) begin
        kind_a = KIND_POS;
        idx_a  = '0;
      end else if (hist[2] == time_id) begin
        kind_a = KIND_TIME;
        idx_a  = '0;
      end else if (hist[2] == status_id) begin
        kind_a = KIND_STATUS;
        idx_a  = '0;
      end else begin
        // unknown identifier: current capture goes on
        kind_a = capture_kind;
        idx_a  = capture_index;
      end
    end
  end

  // Length select, completion and overflow
  always_comb begin
    active = (kind_a != KIND_NONE);
    unique case (kind_a)
      KIND_POS:    cur_len = position_length;
      KIND_TIME:   cur_len = time_length;
      KIND_STATUS: cur_len = status_length;
      KIND_NONE:   cur_len = position_length;
    endcase
    idx_ext  = CMP_W'(idx_a);
    idx_inc  = idx_ext + CMP_W'(1);
    done     = active && (idx_inc == CMP_W'(cur_len));
    overflow = active && !done && (idx_inc == MAX_CMP);
  end

  // Next capture state, flags and counters
  always_comb begin
    capture_kind_next     = kind_a;
    capture_index_next    = idx_a;
    ready_flags_next      = ready_flags;
    header_counter_next   = header_counter + (hdr_hit ? 16'd1 : 16'd0);
    position_counter_next = position_counter;
    time_counter_next     = time_counter;
    status_counter_next   = status_counter;
    if (active) begin
      capture_index_next = idx_inc[IDX_W-1:0];
      unique case (kind_a)
        KIND_POS: begin
          ready_flags_next[0] = done;
          if (done) position_counter_next = position_counter + 16'd1;
        end
        KIND_TIME: begin
          ready_flags_next[1] = done;
          if (done) time_counter_next = time_counter + 16'd1;
        end
        KIND_STATUS: begin
          ready_flags_next[2] = done;
          if (done) status_counter_next = status_counter + 16'd1;
        end
        KIND_NONE: ;
      endcase
      if (done || overflow) begin
        capture_kind_next  = KIND_NONE;
        capture_index_next = '0;
      end
    end
  end

  // State registers, updated once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist[i] <= HIST_RST;
      capture_kind     <= KIND_NONE;
      capture_index    <= '0;
      ready_flags      <= '0;
      header_counter   <= '0;
      position_counter <= '0;
      time_counter     <= '0;
      status_counter   <= '0;
    end else if (in_accept) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) hist[i] <= hist[i+1];
      hist[HIST_DEPTH-1] <= rx_byte;
      capture_kind     <= capture_kind_next;
      capture_index    <= capture_index_next;
      ready_flags      <= ready_flags_next;
      header_counter   <= header_counter_next;
      position_counter <= position_counter_next;
      time_counter     <= time_counter_next;
      status_counter   <= status_counter_next;
    end
  end

  // Result register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: per-byte payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_we    <= active;
      out_kind  <= active ? kind_a : KIND_NONE;
      out_index <= active ? idx_ext[5:0] : 6'd0;
      out_byte  <= active ? rx_byte : 8'd0;
      out_done  <= done;
    end
  end

  assign write_enable   = out_we;
  assign msg_kind       = out_kind;
  assign payload_index  = out_index;
  assign payload_byte   = out_byte;
  assign msg_complete   = out_done;
  assign position_ready = ready_flags[0];
  assign time_ready     = ready_flags[1];
  assign status_ready   = ready_flags[2];
  assign header_count   = header_counter;
  assign position_count = position_counter;
  assign time_count     = time_counter;
  assign status_count   = status_counter;

  // A completed message leaves its own ready flag set
  `GNMC_ASSERT_IMPLY(a_done_sets_ready, clk, rst, out_valid && msg_complete,
    write_enable && ((msg_kind == KIND_POS && position_ready) ||
    (msg_kind == KIND_TIME && time_ready) || (msg_kind == KIND_STATUS && status_ready)))
  // An idle byte carries the empty result
  `GNMC_ASSERT_IMPLY(a_idle_result, clk, rst, out_valid && !write_enable,
    msg_kind == KIND_NONE && payload_index == 6'd0 && !msg_complete)
  // Header, position and time counters move only on an accepted byte
  `GNMC_ASSERT_NEXT(a_count_hold, clk, rst, !in_accept,
    $stable(header_count) && $stable(position_count) && $stable(time_count))
  // Overflow guard: the capture index never reaches the buffer size
  `GNMC_ASSERT_IMPLY(a_index_bound, clk, rst, 1'b1, CMP_W'(capture_index) < MAX_CMP)

endmodule
